FILE: rtl/core/lfp_pkg.sv
// Shared types, constants and the CRC step for the location frame parser.
// No dependencies; every other file of the block imports it.
package lfp_pkg;

    // Frame layout, byte offsets from the first byte of the frame
    localparam int HEADER_BYTES = 34;
    localparam int CRC_BYTES    = 2;
    localparam int MIN_FRAME    = HEADER_BYTES + CRC_BYTES;
    localparam int VER_OFFSET   = 4;
    localparam int FLAG_OFFSET  = 5;
    localparam int TIME_OFFSET  = 8;
    localparam int POS_OFFSET   = 12;
    localparam int ALT_OFFSET   = 20;
    localparam int BATT_OFFSET  = 24;
    localparam int LEN_OFFSET   = 25;
    localparam int DEV_OFFSET   = 26;

    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int TDATA_W   = 224;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Result queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC   = 3'd0,
        REG_VERSION = 3'd1,
        REG_ENC     = 3'd2,
        REG_LIMIT   = 3'd3,
        REG_ROOM    = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_VERSION  = 3'd3,
        ST_ENC      = 3'd4,
        ST_TOO_LONG = 3'd5,
        ST_CRC      = 3'd6,
        ST_NO_ROOM  = 3'd7
    } status_t;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_TEXT    = 1'b1
    } kind_t;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  expected_version;
        logic [7:0]  encrypted_mask;
        logic [7:0]  text_limit;
        logic [8:0]  text_room;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        status_t            status;
        logic [31:0]        epoch_sec;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [15:0] altitude;
        logic [15:0]        h_accuracy;
        logic [7:0]         battery;
        logic [7:0]         flag_bits;
        logic [63:0]        unit_serial;
        logic [7:0]         data_value;
        logic               last;
    } result_t;

    // Which of the two result slots a byte fills; slot 0 is always used first
    typedef struct packed {
        logic first_valid;
        logic second_valid;
    } push_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int i;
        c = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/location_frame_parser.sv
// Location frame parser top level: stream ports, configuration port and packing.
// Depends on lfp_pkg, lfp_cfg_regs, lfp_frame_core and lfp_out_queue.

// One frame byte is taken per cycle while s_tready is high and is handled in
// the cycle it is accepted: the header is captured, the CRC advanced and any
// results written into a four-entry result queue, so a result can be on the
// output in the cycle after its byte. A byte yields no result, a text byte, a
// verdict, or a text byte followed by its verdict; the input is ready while at
// most two results wait, so the block keeps one byte per cycle as long as the
// output drains one result per cycle. Configuration must be written only
// between frames; the block itself does not enforce this.
module location_frame_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] data_byte
    input  logic                          s_tlast,  // frame_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [34:3] epoch_sec, [66:35] latitude, [98:67] longitude,
    // [114:99] altitude, [130:115] h_accuracy, [138:131] battery,
    // [146:139] flag_bits, [210:147] unit_serial, [218:211] data_value, rest 0
    output logic [lfp_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tuser,  // kind
    output logic                          m_tlast,  // last_of_frame
    input  logic                          cfg_we,
    input  logic [lfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfp_pkg::CFG_W-1:0]     cfg_data
);
    import lfp_pkg::*;

    cfg_t    cfg;
    push_t   push;
    result_t res_first, res_second, out_res;
    logic    fire;

    assign fire = s_tvalid && s_tready;

    lfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfp_frame_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fire       (fire),
        .data_byte  (s_tdata),
        .frame_end  (s_tlast),
        .push       (push),
        .res_first  (res_first),
        .res_second (res_second)
    );

    lfp_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .res_first  (res_first),
        .res_second (res_second),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = {5'b00000, out_res.data_value, out_res.unit_serial, out_res.flag_bits,
                      out_res.battery, out_res.h_accuracy, out_res.altitude,
                      out_res.longitude, out_res.latitude, out_res.epoch_sec,
                      out_res.status};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

FILE: rtl/core/lfp_cfg_regs.sv
// Configuration registers of the location frame parser.
// Depends on lfp_pkg for the register index codes and the cfg_t bundle.
module lfp_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lfp_pkg::CFG_W-1:0]     cfg_data,
    output lfp_pkg::cfg_t                 cfg
);
    import lfp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAGIC:   cfg_next.magic_word       = cfg_data;
                REG_VERSION: cfg_next.expected_version = cfg_data[7:0];
                REG_ENC:     cfg_next.encrypted_mask   = cfg_data[7:0];
                REG_LIMIT:   cfg_next.text_limit       = cfg_data[7:0];
                REG_ROOM:    cfg_next.text_room        = cfg_data[8:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word       <= 32'd0;
            cfg_reg.expected_version <= 8'd0;
            cfg_reg.encrypted_mask   <= 8'd1;
            cfg_reg.text_limit       <= 8'd255;
            cfg_reg.text_room        <= 9'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/lfp_frame_core.sv
// Per-byte frame state: header capture, running CRC, checks and result forming.
// Depends on lfp_pkg; feeds up to two results per byte into lfp_out_queue.
module lfp_frame_core (
    input  logic             clk,
    input  logic             rst_n,
    input  lfp_pkg::cfg_t    cfg,
    input  logic             fire,
    input  logic [7:0]       data_byte,
    input  logic             frame_end,
    output lfp_pkg::push_t   push,
    output lfp_pkg::result_t res_first,
    output lfp_pkg::result_t res_second
);
    import lfp_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next, crc_cap;
    logic [15:0] crc_rx_reg, crc_rx_next, crc_rx_cap;
    logic [31:0] magic_reg, magic_next, magic_cap;
    logic [7:0]  version_reg, version_next, version_cap;
    logic [7:0]  flags_reg, flags_next, flags_cap;
    logic [31:0] time_reg, time_next, time_cap;
    logic [63:0] pos_reg, pos_next, pos_cap;
    logic [31:0] altacc_reg, altacc_next, altacc_cap;
    logic [7:0]  batt_reg, batt_next, batt_cap;
    logic [7:0]  len_reg, len_next, len_cap;
    logic [63:0] dev_reg, dev_next, dev_cap;

    logic [COUNT_W-1:0] off;
    logic [COUNT_W-1:0] pos_lane, dev_lane, body_end;
    logic [COUNT_W:0]   n_bytes;
    logic               header_good, emit_text;
    status_t            st;
    result_t            text_res, verdict_res;

    assign off      = count_reg;
    assign pos_lane = off - COUNT_W'(POS_OFFSET);
    assign dev_lane = off - COUNT_W'(DEV_OFFSET);
    assign n_bytes  = {1'b0, off} + (COUNT_W+1)'(1);

    // Header capture; each offset is seen once per frame, so plain lane writes do
    always_comb
    begin
        magic_cap   = magic_reg;
        version_cap = version_reg;
        flags_cap   = flags_reg;
        time_cap    = time_reg;
        pos_cap     = pos_reg;
        altacc_cap  = altacc_reg;
        batt_cap    = batt_reg;
        len_cap     = len_reg;
        dev_cap     = dev_reg;
        if (fire)
        begin
            if (off < COUNT_W'(VER_OFFSET))
                magic_cap[{off[1:0], 3'b000} +: 8] = data_byte;
            else if (off == COUNT_W'(VER_OFFSET))
                version_cap = data_byte;
            else if (off == COUNT_W'(FLAG_OFFSET))
                flags_cap = data_byte;
            else if (off >= COUNT_W'(TIME_OFFSET) && off < COUNT_W'(POS_OFFSET))
                time_cap[{off[1:0], 3'b000} +: 8] = data_byte;
            else if (off >= COUNT_W'(POS_OFFSET) && off < COUNT_W'(ALT_OFFSET))
                pos_cap[{pos_lane[2:0], 3'b000} +: 8] = data_byte;
            else if (off >= COUNT_W'(ALT_OFFSET) && off < COUNT_W'(BATT_OFFSET))
                altacc_cap[{off[1:0], 3'b000} +: 8] = data_byte;
            else if (off == COUNT_W'(BATT_OFFSET))
                batt_cap = data_byte;
            else if (off == COUNT_W'(LEN_OFFSET))
                len_cap = data_byte;
            else if (off >= COUNT_W'(DEV_OFFSET) && off < COUNT_W'(HEADER_BYTES))
                dev_cap[{dev_lane[2:0], 3'b000} +: 8] = data_byte;
        end
    end

    // CRC covers header and text; the two bytes after the body are the sent CRC
    assign body_end = COUNT_W'(HEADER_BYTES) + {1'b0, len_cap};

    always_comb
    begin
        crc_cap    = crc_reg;
        crc_rx_cap = crc_rx_reg;
        if (fire)
        begin
            if (off < body_end)
                crc_cap = crc16_byte(crc_reg, data_byte);
            else if (off == body_end)
                crc_rx_cap[7:0] = data_byte;
            else if (off == body_end + COUNT_W'(1))
                crc_rx_cap[15:8] = data_byte;
        end
    end

    assign header_good = (magic_cap == cfg.magic_word)
                      && (version_cap == cfg.expected_version)
                      && ((flags_cap & cfg.encrypted_mask) == 8'd0)
                      && (len_cap <= cfg.text_limit)
                      && (cfg.text_room > {1'b0, len_cap});

    assign emit_text = fire && off >= COUNT_W'(HEADER_BYTES) && off < body_end && header_good;

    always_comb
    begin
        priority if (cfg.text_room == 9'd0)
            st = ST_NO_ROOM;
        else if (n_bytes < (COUNT_W+1)'(MIN_FRAME))
            st = ST_SHORT;
        else if (magic_cap != cfg.magic_word)
            st = ST_MAGIC;
        else if (version_cap != cfg.expected_version)
            st = ST_VERSION;
        else if ((flags_cap & cfg.encrypted_mask) != 8'd0)
            st = ST_ENC;
        else if (len_cap > cfg.text_limit)
            st = ST_TOO_LONG;
        else if (n_bytes < (COUNT_W+1)'(MIN_FRAME) + {2'b00, len_cap})
            st = ST_SHORT;
        else if (crc_rx_cap != crc_cap)
            st = ST_CRC;
        else if (len_cap != 8'd0 && cfg.text_room <= {1'b0, len_cap})
            st = ST_NO_ROOM;
        else
            st = ST_OK;
    end

    always_comb
    begin
        text_res            = '0;
        text_res.kind       = KIND_TEXT;
        text_res.status     = ST_OK;
        text_res.data_value = data_byte;

        verdict_res        = '0;
        verdict_res.kind   = KIND_VERDICT;
        verdict_res.status = st;
        verdict_res.last   = 1'b1;
        if (st == ST_OK)
        begin
            verdict_res.epoch_sec   = time_cap;
            verdict_res.latitude    = pos_cap[31:0];
            verdict_res.longitude   = pos_cap[63:32];
            verdict_res.altitude    = altacc_cap[15:0];
            verdict_res.h_accuracy  = altacc_cap[31:16];
            verdict_res.battery     = batt_cap;
            verdict_res.flag_bits   = flags_cap;
            verdict_res.unit_serial = dev_cap;
            verdict_res.data_value  = len_cap;
        end
    end

    // Text byte first when both appear on the same byte
    always_comb
    begin
        push.first_valid  = emit_text || (fire && frame_end);
        push.second_valid = emit_text && fire && frame_end;
        res_first         = emit_text ? text_res : verdict_res;
        res_second        = verdict_res;
    end

    always_comb
    begin
        count_next   = count_reg;
        crc_next     = crc_cap;
        crc_rx_next  = crc_rx_cap;
        magic_next   = magic_cap;
        version_next = version_cap;
        flags_next   = flags_cap;
        time_next    = time_cap;
        pos_next     = pos_cap;
        altacc_next  = altacc_cap;
        batt_next    = batt_cap;
        len_next     = len_cap;
        dev_next     = dev_cap;
        if (fire && count_reg != {COUNT_W{1'b1}})
            count_next = count_reg + COUNT_W'(1);
        if (fire && frame_end)
        begin
            count_next   = '0;
            crc_next     = CRC_INIT;
            crc_rx_next  = '0;
            magic_next   = '0;
            version_next = '0;
            flags_next   = '0;
            time_next    = '0;
            pos_next     = '0;
            altacc_next  = '0;
            batt_next    = '0;
            len_next     = '0;
            dev_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            crc_rx_reg  <= '0;
            magic_reg   <= '0;
            version_reg <= '0;
            flags_reg   <= '0;
            time_reg    <= '0;
            pos_reg     <= '0;
            altacc_reg  <= '0;
            batt_reg    <= '0;
            len_reg     <= '0;
            dev_reg     <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            crc_rx_reg  <= crc_rx_next;
            magic_reg   <= magic_next;
            version_reg <= version_next;
            flags_reg   <= flags_next;
            time_reg    <= time_next;
            pos_reg     <= pos_next;
            altacc_reg  <= altacc_next;
            batt_reg    <= batt_next;
            len_reg     <= len_next;
            dev_reg     <= dev_next;
        end
    end

endmodule

FILE: rtl/core/lfp_out_queue.sv
// Four-entry result queue between the frame logic and the output stream.
// Depends on lfp_pkg; takes up to two results per cycle, gives one.
module lfp_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  lfp_pkg::push_t   push,
    input  lfp_pkg::result_t res_first,
    input  lfp_pkg::result_t res_second,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output lfp_pkg::result_t out_res
);
    import lfp_pkg::*;

    result_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QPTR_W-1:0]  wr_ptr_2nd;
    logic               pop;
    logic [QCNT_W-1:0]  n_push;

    // Room for two results is kept whenever an item may enter
    assign in_ready   = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign out_valid  = count_reg != '0;
    assign out_res    = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_2nd = wr_ptr_reg + QPTR_W'(1);
    assign n_push     = QCNT_W'(push.first_valid) + QCNT_W'(push.second_valid);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push[QPTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + n_push - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
            mem_reg[wr_ptr_reg] <= res_first;
        if (push.second_valid)
            mem_reg[wr_ptr_2nd] <= res_second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/lfp_checker.sv
// Port-level checks for the location frame parser, bound to the top level.
// Depends on lfp_pkg for the kind and status codes.
module lfp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lfp_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tuser,
    input logic                        m_tlast
);
    import lfp_pkg::*;

    // A waiting item must stay offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    // Text items never close a frame and never carry a status
    a_text_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_TEXT |-> !m_tlast && m_tdata[2:0] == ST_OK)
        else $error("text item with status or frame close");

    // Every verdict closes its frame
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_VERDICT |-> m_tlast)
        else $error("verdict without frame close");

    // A failed verdict reports no header fields
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_VERDICT && m_tdata[2:0] != ST_OK
        |-> m_tdata[TDATA_W-1:3] == '0)
        else $error("failed verdict carries header fields");

endmodule

bind location_frame_parser lfp_checker u_lfp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
